// ===== hw/rtl/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types, constants and the reciprocal table of the box blur row filter.
// ----------------------------------------------------------------------------
package bbr_pkg;

  // Pixel layout: three 8-bit channels, red in the top byte
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int CH_R   = 2;
  localparam int CH_G   = 1;
  localparam int CH_B   = 0;

  // Radius register, row position counter
  localparam int RADIUS_W       = 6;
  localparam int POS_W          = 6;
  localparam int POS_MAX        = 63;
  localparam int MAX_RADIUS_DEF = 32;

  // Reciprocal scaling: q = (sum * recip) >> RECIP_SHIFT, exact for sums below 2^15
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 22;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic fill;   // load src into both registers of every cell
    logic shift;  // advance history and window lines by one
    pix_t src;    // pixel entering the chain
  } cell_ctrl_t;

  // ceil(2^22 / (2r+1)) for r = 0..32
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIUS_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      6'd0:    m = 23'd4194304;
      6'd1:    m = 23'd1398102;
      6'd2:    m = 23'd838861;
      6'd3:    m = 23'd599187;
      6'd4:    m = 23'd466034;
      6'd5:    m = 23'd381301;
      6'd6:    m = 23'd322639;
      6'd7:    m = 23'd279621;
      6'd8:    m = 23'd246724;
      6'd9:    m = 23'd220753;
      6'd10:   m = 23'd199729;
      6'd11:   m = 23'd182362;
      6'd12:   m = 23'd167773;
      6'd13:   m = 23'd155345;
      6'd14:   m = 23'd144632;
      6'd15:   m = 23'd135301;
      6'd16:   m = 23'd127101;
      6'd17:   m = 23'd119838;
      6'd18:   m = 23'd113360;
      6'd19:   m = 23'd107547;
      6'd20:   m = 23'd102301;
      6'd21:   m = 23'd97542;
      6'd22:   m = 23'd93207;
      6'd23:   m = 23'd89241;
      6'd24:   m = 23'd85599;
      6'd25:   m = 23'd82242;
      6'd26:   m = 23'd79138;
      6'd27:   m = 23'd76261;
      6'd28:   m = 23'd73585;
      6'd29:   m = 23'd71090;
      6'd30:   m = 23'd68760;
      6'd31:   m = 23'd66577;
      6'd32:   m = 23'd64528;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/bbr_cell.sv =====
// ----------------------------------------------------------------------------
// bbr_cell
// One cell of the pixel chain: a history register and a window delay register.
// ----------------------------------------------------------------------------
module bbr_cell (
  input  logic               clk_i,
  input  bbr_pkg::cell_ctrl_t ctrl_i,
  input  logic               ins_i,        // this cell is the window entry point or above
  input  bbr_pkg::pix_t      hist_prev_i,  // newer neighbour in the history line
  input  bbr_pkg::pix_t      dly_next_i,   // younger neighbour in the window line
  output bbr_pkg::pix_t      hist_o,
  output bbr_pkg::pix_t      dly_o
);

  bbr_pkg::pix_t hist_q, hist_d;
  bbr_pkg::pix_t dly_q,  dly_d;

  // Fill on row start, otherwise shift; window line loads src at its entry point
  always_comb begin
    hist_d = hist_q;
    dly_d  = dly_q;
    if (ctrl_i.fill) begin
      hist_d = ctrl_i.src;
      dly_d  = ctrl_i.src;
    end else if (ctrl_i.shift) begin
      hist_d = hist_prev_i;
      dly_d  = ins_i ? ctrl_i.src : dly_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
    dly_q  <= dly_d;
  end

  assign hist_o = hist_q;
  assign dly_o  = dly_q;

endmodule

// ===== hw/rtl/bbr_scale.sv =====
// ----------------------------------------------------------------------------
// bbr_scale
// Divides one channel's window sum by the window width through a reciprocal
// multiply, and holds the quotient as the output register of that channel.
// ----------------------------------------------------------------------------
module bbr_scale #(
  parameter int SUM_W = 15
) (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [SUM_W-1:0]               sum_i,
  input  logic [bbr_pkg::RECIP_W-1:0]    recip_i,
  output logic [bbr_pkg::CH_W-1:0]       quot_o
);

  localparam int PROD_W = SUM_W + bbr_pkg::RECIP_W;

  logic [PROD_W-1:0]         prod;
  logic [bbr_pkg::CH_W-1:0]  quot_q, quot_d;

  // Quotient fits in one byte, upper product bits are zero
  assign prod   = sum_i * recip_i;
  assign quot_d = prod[bbr_pkg::RECIP_SHIFT +: bbr_pkg::CH_W];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/box_blur_row_filter_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_row_filter_unit
// Horizontal box blur of RGB rows with clamp-to-edge padding.
// ----------------------------------------------------------------------------
// Pixels come in on the input channel (valid/stall), one per transfer, with
// row_end on the last pixel of a row. Blurred pixels leave on the output
// channel; row_done marks the last one of a row. Output j is issued once
// pixel j+radius has arrived; the row_end pixel is followed by a flush that
// repeats the edge pixel to emit the rest of the row, input stalled meanwhile.
// Throughput: one pixel per cycle inside a row, unless the output stalls or a resync runs.
// Path: the transfer loads the running-sum register, and once the output
// register is free the reciprocal multiply of that sum is loaded into it,
// from where the result is valid.
// A radius write in mid-row triggers a resync that rotates the history chain
// once to rebuild the sum, again if written during it; input is stalled then.
// The radius register saturates at MAX_RADIUS.
// Reset clears control state and the sums; the pixel chain needs no clearing
// as the first pixel of each row fills all of it. If the receiver stalls, the
// output register holds and input stalls once the sum stage is also full.
// ----------------------------------------------------------------------------
module box_blur_row_filter_unit #(
  parameter int MAX_RADIUS = bbr_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          radius_we_i,
  input  logic [bbr_pkg::RADIUS_W-1:0]  radius_i,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bbr_pkg::CH_W-1:0]      red_i,
  input  logic [bbr_pkg::CH_W-1:0]      green_i,
  input  logic [bbr_pkg::CH_W-1:0]      blue_i,
  input  logic                          row_end_i,
  // pixel output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bbr_pkg::CH_W-1:0]      out_red_o,
  output logic [bbr_pkg::CH_W-1:0]      out_green_o,
  output logic [bbr_pkg::CH_W-1:0]      out_blue_o,
  output logic                          row_done_o
);

  localparam int DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int LEN_W  = RW + 1;
  localparam int CNT_W  = $clog2(DEPTH);
  localparam int SUM_W  = bbr_pkg::CH_W + $clog2(DEPTH);
  localparam int NCH    = bbr_pkg::NUM_CH;
  localparam int RAD_W  = bbr_pkg::RADIUS_W;
  localparam int POS_W  = bbr_pkg::POS_W;

  localparam logic [RAD_W-1:0] RAD_LIMIT = RAD_W'(MAX_RADIUS);
  localparam logic [POS_W-1:0] POS_SAT   = POS_W'(bbr_pkg::POS_MAX);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DEPTH - 1);

  // Sequencer states
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_SYNC  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [RW-1:0]     r_q, r_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              again_q, again_d;
  logic [SUM_W-1:0]  sum_q [NCH];
  logic [SUM_W-1:0]  sum_d [NCH];
  bbr_pkg::pix_t     edge_q, edge_d;
  logic              emit_q, emit_d;
  logic              emit_done_q, emit_done_d;
  logic              out_valid_q, out_valid_d;
  logic              out_done_q, out_done_d;

  logic [LEN_W-1:0]  len_m1, len;
  logic              out_free, step_ok, out_load;
  logic              in_acc, flush_step, sync_step, pos_zero;
  logic              run_emit, flush_emit, flush_last, sync_take, sync_last;
  logic              step_emit, step_done;
  bbr_pkg::pix_t     in_pix, src, leave, feed;
  bbr_pkg::cell_ctrl_t ctrl;
  bbr_pkg::pix_t     hist [DEPTH];
  bbr_pkg::pix_t     dly  [DEPTH];
  logic [DEPTH-1:0]  ins;
  logic [bbr_pkg::RECIP_W-1:0] recip;
  logic [bbr_pkg::CH_W-1:0]    quot [NCH];

  // Window geometry
  assign len_m1 = {r_q, 1'b0};
  assign len    = len_m1 + LEN_W'(1);

  // Handshake and stage control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_ok    = !emit_q || out_free;
  assign out_load   = emit_q && out_free;
  assign in_stall_o = !((state_q == ST_RUN) && step_ok);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign flush_step = (state_q == ST_FLUSH) && step_ok;
  assign sync_step  = (state_q == ST_SYNC);
  assign pos_zero   = (pos_q == '0);

  assign in_pix[bbr_pkg::CH_R] = red_i;
  assign in_pix[bbr_pkg::CH_G] = green_i;
  assign in_pix[bbr_pkg::CH_B] = blue_i;

  // Pixel entering the chain
  always_comb begin
    case (state_q)
      ST_RUN:   src = in_pix;
      ST_FLUSH: src = edge_q;
      ST_SYNC:  src = feed;
      default:  src = in_pix;
    endcase
  end

  assign ctrl.fill  = in_acc && pos_zero;
  assign ctrl.shift = (in_acc && !pos_zero) || flush_step || sync_step;
  assign ctrl.src   = src;

  // Cell chain: history newest at cell 0, window line drains out of cell 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    bbr_pkg::pix_t prev, next;
    assign ins[k] = (LEN_W'(k) >= len_m1);
    if (k == 0) begin : g_head
      assign prev = src;
    end else begin : g_body
      assign prev = hist[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign next = src;
    end else begin : g_inner
      assign next = dly[k+1];
    end
    bbr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .ins_i       (ins[k]),
      .hist_prev_i (prev),
      .dly_next_i  (next),
      .hist_o      (hist[k]),
      .dly_o       (dly[k])
    );
  end

  assign leave = dly[0];
  assign feed  = hist[DEPTH-1];

  // Emission decisions
  assign run_emit   = (pos_q >= POS_W'(r_q));
  assign flush_emit = ((POS_W+1)'(pos_q) + (POS_W+1)'(cnt_q)) >= (POS_W+1)'(r_q);
  assign flush_last = (cnt_q == CNT_W'(r_q));
  assign sync_take  = ((CNT_W+1)'(cnt_q) + (CNT_W+1)'(len)) >= (CNT_W+1)'(DEPTH);
  assign sync_last  = (cnt_q == CNT_LAST);
  assign step_emit  = (in_acc && run_emit) || (flush_step && flush_emit);
  assign step_done  = (in_acc && row_end_i && (r_q == '0)) || (flush_step && flush_last);

  // Sequencer, running sums and radius register
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    again_d = again_q;
    edge_d  = edge_q;
    sum_d   = sum_q;

    case (state_q)
      ST_RUN: begin
        if (in_acc) begin
          edge_d = in_pix;
          if (row_end_i) begin
            if (r_q != '0) begin
              state_d = ST_FLUSH;
              cnt_d   = CNT_W'(1);
            end else begin
              pos_d = '0;
            end
          end else if (pos_q != POS_SAT) begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (flush_step) begin
          if (flush_last) begin
            state_d = ST_RUN;
            pos_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_SYNC: begin
        if (sync_last) begin
          if (again_q) begin
            again_d = 1'b0;
            cnt_d   = '0;
          end else begin
            state_d = ST_RUN;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase

    // Per-channel sum update
    for (int c = 0; c < NCH; c++) begin
      if (ctrl.fill) begin
        sum_d[c] = SUM_W'(len) * SUM_W'(src[c]);
      end else if (sync_step) begin
        if (sync_last && again_q) begin
          sum_d[c] = '0;
        end else if (sync_take) begin
          sum_d[c] = sum_q[c] + SUM_W'(src[c]);
        end
      end else if (ctrl.shift) begin
        sum_d[c] = sum_q[c] + SUM_W'(src[c]) - SUM_W'(leave[c]);
      end
    end

    // Radius write; mid-row it forces a rebuild of the window
    if (radius_we_i) begin
      r_d = (radius_i > RAD_LIMIT) ? RW'(MAX_RADIUS) : radius_i[RW-1:0];
      if (state_q == ST_SYNC) begin
        again_d = 1'b1;
      end else if (!pos_zero) begin
        state_d = ST_SYNC;
        cnt_d   = '0;
        for (int c = 0; c < NCH; c++) begin
          sum_d[c] = '0;
        end
      end
    end
  end

  // Sum stage and output register flags
  always_comb begin
    emit_d      = emit_q;
    emit_done_d = emit_done_q;
    if (step_emit) begin
      emit_d      = 1'b1;
      emit_done_d = step_done;
    end else if (out_load) begin
      emit_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_done_d  = out_done_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_done_d  = emit_done_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      r_q         <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      again_q     <= 1'b0;
      emit_q      <= 1'b0;
      emit_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      again_q     <= again_d;
      emit_q      <= emit_d;
      emit_done_q <= emit_done_d;
      out_valid_q <= out_valid_d;
      out_done_q  <= out_done_d;
      sum_q       <= sum_d;
    end
  end

  // Edge pixel repeated by the flush
  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
  end

  // Reciprocal multiply into the output register
  assign recip = bbr_pkg::recip(RAD_W'(r_q));

  for (genvar c = 0; c < NCH; c++) begin : g_scale
    bbr_scale #(
      .SUM_W (SUM_W)
    ) u_scale (
      .clk_i   (clk_i),
      .load_i  (out_load),
      .sum_i   (sum_q[c]),
      .recip_i (recip),
      .quot_o  (quot[c])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = quot[bbr_pkg::CH_R];
  assign out_green_o = quot[bbr_pkg::CH_G];
  assign out_blue_o  = quot[bbr_pkg::CH_B];
  assign row_done_o  = out_done_q;

  // Input is held off for the whole resync pass
  a_sync_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SYNC) |-> in_stall_o)
    else $error("input transfer possible during resync");

  // A pending sum is kept until the output register takes it
  a_emit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q && !out_free) |=> (emit_q && $stable(emit_done_q)))
    else $error("pending result lost");

  // Final flush step always issues the row's last result
  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_step && flush_last) |=> (emit_q && emit_done_q))
    else $error("row end not marked");

endmodule

// ===== verif/tb_box_blur_row_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_box_blur_row_filter_unit
// Self-checking bench for the horizontal box blur row filter.
// ----------------------------------------------------------------------------
// A short table of directed pixels and radius writes comes first. Where the
// blurred result is obvious (radius 0, one-pixel rows) it is typed in. It
// then runs random rows of mixed length: single pixels, short rows, rows past
// the position counter's saturation, radius changes between and inside rows.
// Every accepted pixel runs through a behavioural copy of the filter, and
// each output transfer is compared field by field with the oldest expected
// pixel. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_box_blur_row_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W     = bbr_pkg::CH_W;
  localparam int RAD_W    = bbr_pkg::RADIUS_W;
  localparam int MAXR     = bbr_pkg::MAX_RADIUS_DEF;
  localparam int RING_N   = 2 * MAXR + 1;
  localparam int SETTLE   = RING_N + 16;   // covers flush and resync cycles
  localparam int WD_LIMIT = 4000;
  localparam int PHASE_N  = 92;            // minimum random pixels per idling phase

  // One blurred pixel as seen on the output channel
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            done;
  } blur_px_t;

  // Directed stimulus row: a radius write or a pixel, with optional literal
  typedef struct packed {
    logic             is_cfg;
    logic [RAD_W-1:0] cfg_val;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             row_end;
    logic             has_lit;
    blur_px_t         lit;
  } dir_row_t;

  // DUT ports
  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             radius_we_i = 1'b0;
  logic [RAD_W-1:0] radius_i    = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [CH_W-1:0]  red_i       = '0;
  logic [CH_W-1:0]  green_i     = '0;
  logic [CH_W-1:0]  blue_i      = '0;
  logic             row_end_i   = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [CH_W-1:0]  out_red_o;
  logic [CH_W-1:0]  out_green_o;
  logic [CH_W-1:0]  out_blue_o;
  logic             row_done_o;

  // Blur predictor state
  bbr_pkg::pix_t             ring_px [RING_N];
  int unsigned               ring_head  = 0;
  logic [bbr_pkg::POS_W-1:0] pos_cnt    = '0;
  logic [RAD_W-1:0]          radius_reg = '0;
  bbr_pkg::pix_t             last_px    = '0;

  blur_px_t            blur_exp_q [$];
  blur_px_t            blur_want;
  dir_row_t            dir_q [$];

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned fail_cnt    = 0;
  int unsigned pix_sent    = 0;
  int unsigned rows_sent   = 0;
  int unsigned blur_seen   = 0;
  int unsigned cfg_writes  = 0;
  int unsigned quiet_cnt   = 0;

  box_blur_row_filter_unit #(
    .MAX_RADIUS (MAXR)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_we_i (radius_we_i),
    .radius_i    (radius_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .row_end_i   (row_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .row_done_o  (row_done_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_radius();
    return (radius_reg > MAXR) ? MAXR : int'(radius_reg);
  endfunction

  task automatic push_ring(input bbr_pkg::pix_t px);
    ring_head = (ring_head + 1) % RING_N;
    ring_px[ring_head] = px;
  endtask

  // Append one expected blurred pixel
  task automatic expect_blur(input blur_px_t b);
    blur_exp_q = {blur_exp_q, b};
  endtask

  // Floor mean over the newest 2r+1 ring entries
  function automatic blur_px_t window_mean(input int unsigned r);
    int unsigned span;
    int unsigned idx;
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    blur_px_t    m;
    span = 2 * r + 1;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int unsigned t = 0; t < span; t++) begin
      idx = (ring_head + RING_N - t) % RING_N;
      sr += ring_px[idx][bbr_pkg::CH_R];
      sg += ring_px[idx][bbr_pkg::CH_G];
      sb += ring_px[idx][bbr_pkg::CH_B];
    end
    m.red   = CH_W'(sr / span);
    m.green = CH_W'(sg / span);
    m.blue  = CH_W'(sb / span);
    m.done  = 1'b0;
    return m;
  endfunction

  // Advance the model by one accepted pixel and queue what it causes
  task automatic predict_blur(input bbr_pkg::pix_t px, input logic last,
                              input logic use_lit, input blur_px_t lit);
    blur_px_t    res [MAXR+1];
    int unsigned n;
    int unsigned r;
    r = eff_radius();
    n = 0;
    if (pos_cnt == 0) begin
      // first pixel of a row pads the whole window
      for (int i = 0; i < RING_N; i++) ring_px[i] = px;
    end else begin
      push_ring(px);
    end
    last_px = px;
    if (pos_cnt >= r) begin
      res[n] = window_mean(r);
      n++;
    end
    if (last) begin
      // flush: repeat the edge pixel radius times
      for (int unsigned t = 1; t <= r; t++) begin
        push_ring(last_px);
        if (pos_cnt + t >= r) begin
          res[n] = window_mean(r);
          n++;
        end
      end
      if (n > 0) res[n-1].done = 1'b1;
      pos_cnt = '0;
      rows_sent++;
    end else if (pos_cnt < bbr_pkg::POS_MAX) begin
      pos_cnt++;
    end
    if (use_lit) begin
      expect_blur(lit);
    end else begin
      for (int unsigned i = 0; i < n; i++) expect_blur(res[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Pixel transfer with random sender gaps
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input logic e,
                            input logic use_lit, input blur_px_t lit);
    bbr_pkg::pix_t px;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    row_end_i  <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    px[bbr_pkg::CH_R] = r;
    px[bbr_pkg::CH_G] = g;
    px[bbr_pkg::CH_B] = b;
    predict_blur(px, e, use_lit, lit);
    pix_sent++;
  endtask

  // Let every expected pixel out, then allow the pipeline to go quiet
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (blur_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_radius(input logic [RAD_W-1:0] v);
    drain_pipe();
    radius_we_i <= 1'b1;
    radius_i    <= v;
    @(posedge clk_i);
    radius_we_i <= 1'b0;
    radius_reg   = v;
    cfg_writes++;
  endtask

  // Mostly small radii, some at and above saturation
  function automatic logic [RAD_W-1:0] pick_radius();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40)      return RAD_W'($urandom_range(4, 0));
    else if (sel < 55) return RAD_W'(MAXR);
    else if (sel < 65) return RAD_W'($urandom_range(63, 33));
    else               return RAD_W'($urandom_range(31, 0));
  endfunction

  // Channel value with extra weight on the extremes
  function automatic logic [CH_W-1:0] rand_chan();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0)      return '0;
    else if (sel == 1) return '1;
    else               return CH_W'($urandom_range(255, 0));
  endfunction

  function automatic dir_row_t dir_cfg(input logic [RAD_W-1:0] v);
    dir_row_t d;
    d = '0;
    d.is_cfg  = 1'b1;
    d.cfg_val = v;
    return d;
  endfunction

  function automatic dir_row_t dir_px(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                      input logic [CH_W-1:0] b, input logic e);
    dir_row_t d;
    d = '0;
    d.red     = r;
    d.green   = g;
    d.blue    = b;
    d.row_end = e;
    return d;
  endfunction

  function automatic dir_row_t dir_lit(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                       input logic [CH_W-1:0] b, input logic e,
                                       input blur_px_t want);
    dir_row_t d;
    d = dir_px(r, g, b, e);
    d.has_lit = 1'b1;
    d.lit     = want;
    return d;
  endfunction

  // Append one row to the directed table
  task automatic add_row(input dir_row_t d);
    dir_q = {dir_q, d};
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall and output checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      blur_seen++;
      if (blur_exp_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected output, expected none, actual %0h %0h %0h %0b",
                 $time, out_red_o, out_green_o, out_blue_o, row_done_o);
      end else begin
        blur_want = blur_exp_q.pop_front();
        check_field("out_red",   blur_want.red,   out_red_o);
        check_field("out_green", blur_want.green, out_green_o);
        check_field("out_blue",  blur_want.blue,  out_blue_o);
        check_field("row_done",  CH_W'(blur_want.done), CH_W'(row_done_o));
      end
    end
  end

  // Watchdog: cycles without any transfer or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || radius_we_i) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= WD_LIMIT) begin
        $display("%0t: timeout, %0d outputs still expected", $time, blur_exp_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t    d;
    int unsigned phase_items;
    int unsigned row_len;
    int unsigned cut_at;
    logic        mid_change;

    // radius 0 straight after reset: output equals input
    add_row(dir_lit(8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}));
    add_row(dir_lit(8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}));
    add_row(dir_lit(8'h5A, 8'hA5, 8'h0F, 1'b0, '{8'h5A, 8'hA5, 8'h0F, 1'b0}));
    add_row(dir_lit(8'hFF, 8'h00, 8'h80, 1'b1, '{8'hFF, 8'h00, 8'h80, 1'b1}));
    // one-pixel row at radius 1, then a four-pixel row
    add_row(dir_cfg(6'd1));
    add_row(dir_lit(8'h12, 8'h34, 8'h56, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1}));
    add_row(dir_px(8'hFF, 8'h00, 8'h00, 1'b0));
    add_row(dir_px(8'h00, 8'hFF, 8'h00, 1'b0));
    add_row(dir_px(8'h00, 8'h00, 8'hFF, 1'b0));
    add_row(dir_px(8'hFF, 8'hFF, 8'hFF, 1'b1));
    // short row at the largest radius: everything comes out at row end
    add_row(dir_cfg(6'd32));
    add_row(dir_px(8'hFF, 8'h00, 8'hFF, 1'b0));
    add_row(dir_px(8'h00, 8'hFF, 8'h00, 1'b0));
    add_row(dir_px(8'hFF, 8'hFF, 8'h01, 1'b1));
    // radius above the maximum saturates
    add_row(dir_cfg(6'd33));
    add_row(dir_lit(8'hC8, 8'h64, 8'h32, 1'b1, '{8'hC8, 8'h64, 8'h32, 1'b1}));
    add_row(dir_cfg(6'd63));
    add_row(dir_lit(8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}));
    add_row(dir_px(8'h00, 8'h00, 8'h00, 1'b0));
    add_row(dir_px(8'hFF, 8'hFF, 8'hFF, 1'b1));
    // radius change in the middle of a row
    add_row(dir_cfg(6'd2));
    add_row(dir_px(8'd10, 8'd20, 8'd30, 1'b0));
    add_row(dir_px(8'd40, 8'd50, 8'd60, 1'b0));
    add_row(dir_px(8'd70, 8'd80, 8'd90, 1'b0));
    add_row(dir_cfg(6'd5));
    add_row(dir_px(8'd100, 8'd110, 8'd120, 1'b0));
    add_row(dir_px(8'd130, 8'd140, 8'd150, 1'b0));
    add_row(dir_px(8'd160, 8'd170, 8'd180, 1'b1));
    add_row(dir_cfg(6'd0));
    add_row(dir_lit(8'h01, 8'h02, 8'h03, 1'b1, '{8'h01, 8'h02, 8'h03, 1'b1}));

    // Reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    foreach (dir_q[i]) begin
      d = dir_q[i];
      if (d.is_cfg) set_radius(d.cfg_val);
      else          send_pixel(d.red, d.green, d.blue, d.row_end, d.has_lit, d.lit);
    end

    // Random rows under four idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      drain_pipe();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      set_radius(pick_radius());
      phase_items = 0;
      while (phase_items < PHASE_N) begin
        if ($urandom_range(99) < 30) set_radius(pick_radius());
        case ($urandom_range(99)) inside
          [0:7]:   row_len = $urandom_range(80, 64);
          [8:27]:  row_len = 1;
          default: row_len = $urandom_range(12, 2);
        endcase
        mid_change = (row_len > 1) && ($urandom_range(99) < 6);
        cut_at     = (row_len > 1) ? $urandom_range(row_len - 1, 1) : 0;
        for (int unsigned k = 0; k < row_len; k++) begin
          if (mid_change && k == cut_at) set_radius(pick_radius());
          send_pixel(rand_chan(), rand_chan(), rand_chan(), k == row_len - 1,
                     1'b0, '0);
        end
        phase_items += row_len;
      end
    end

    // Wind down
    drain_pipe();
    $display("Sent %0d pixels in %0d rows, checked %0d blurred pixels, %0d radius writes.",
             pix_sent, rows_sent, blur_seen, cfg_writes);
    $display("Radius 0 to 63 incl. saturation, mid-row changes, gaps and stalls mixed.");
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("status: fail");
    end
    $finish;
  end

endmodule
